// File: rtl/linear_probe_hash_set_macros.svh
// -----------------------------------------------------------------------------
// linear_probe_hash_set assertion macros
// Shared concurrent assertion forms for the hash set RTL.
// -----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_SET_MACROS_SVH
`define LINEAR_PROBE_HASH_SET_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LPHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LPHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lphs_pkg.sv
// -----------------------------------------------------------------------------
// lphs_pkg
// Types, constants and microcode encodings shared by the hash set modules.
// -----------------------------------------------------------------------------
package lphs_pkg;

  localparam int CFG_W           = 5;
  localparam int SIZE_MAX        = 2 ** CFG_W - 1;
  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DEF_KEY_WIDTH   = 16;
  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 5'd11;

  localparam int STEP_W = 4;

  // Microprogram addresses.
  localparam logic [STEP_W-1:0] S_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] S_MOD     = 4'd1;
  localparam logic [STEP_W-1:0] S_SETPOS  = 4'd2;
  localparam logic [STEP_W-1:0] S_READ    = 4'd3;
  localparam logic [STEP_W-1:0] S_EMPTY   = 4'd4;
  localparam logic [STEP_W-1:0] S_MATCH   = 4'd5;
  localparam logic [STEP_W-1:0] S_ADVANCE = 4'd6;
  localparam logic [STEP_W-1:0] S_FULL    = 4'd7;
  localparam logic [STEP_W-1:0] S_STORE   = 4'd8;
  localparam logic [STEP_W-1:0] S_HIT     = 4'd9;

  typedef enum logic [3:0] {
    OP_NOP     = 4'd0,
    OP_IDLE    = 4'd1,
    OP_MOD     = 4'd2,
    OP_SETPOS  = 4'd3,
    OP_READ    = 4'd4,
    OP_ADVANCE = 4'd5,
    OP_STORE   = 4'd6,
    OP_HIT     = 4'd7,
    OP_FULL    = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_START  = 3'd2,
    COND_MORE_BITS = 3'd3,
    COND_EMPTY     = 3'd4,
    COND_MATCH     = 3'd5,
    COND_NOT_LAST  = 3'd6
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic more_bits;
    logic empty;
    logic match;
    logic last;
  } status_t;

endpackage

// File: rtl/lphs_ucode_rom.sv
// -----------------------------------------------------------------------------
// lphs_ucode_rom
// Read-only microprogram: one control word for each sequencer step.
// -----------------------------------------------------------------------------
module lphs_ucode_rom
  import lphs_pkg::*;
(
  input  logic [STEP_W-1:0] step,
  output ctrl_word_t        ctrl
);

  always_comb begin
    unique case (step)
      S_IDLE:    ctrl = '{op: OP_IDLE,    cond: COND_NO_START,  target: S_IDLE};
      S_MOD:     ctrl = '{op: OP_MOD,     cond: COND_MORE_BITS, target: S_MOD};
      S_SETPOS:  ctrl = '{op: OP_SETPOS,  cond: COND_NEVER,     target: S_IDLE};
      S_READ:    ctrl = '{op: OP_READ,    cond: COND_NEVER,     target: S_IDLE};
      S_EMPTY:   ctrl = '{op: OP_NOP,     cond: COND_EMPTY,     target: S_STORE};
      S_MATCH:   ctrl = '{op: OP_NOP,     cond: COND_MATCH,     target: S_HIT};
      S_ADVANCE: ctrl = '{op: OP_ADVANCE, cond: COND_NOT_LAST,  target: S_READ};
      S_FULL:    ctrl = '{op: OP_FULL,    cond: COND_ALWAYS,    target: S_IDLE};
      S_STORE:   ctrl = '{op: OP_STORE,   cond: COND_ALWAYS,    target: S_IDLE};
      S_HIT:     ctrl = '{op: OP_HIT,     cond: COND_ALWAYS,    target: S_IDLE};
      default:   ctrl = '{op: OP_NOP,     cond: COND_ALWAYS,    target: S_IDLE};
    endcase
  end

endmodule

// File: rtl/lphs_sequencer.sv
// -----------------------------------------------------------------------------
// lphs_sequencer
// Step counter with conditional jumps, driven by the microprogram ROM.
// -----------------------------------------------------------------------------
module lphs_sequencer
  import lphs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  status_t    status,
  output ctrl_word_t ctrl,
  output logic       busy
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              take;

  lphs_ucode_rom u_rom (
    .step (step),
    .ctrl (ctrl)
  );

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:    take = 1'b1;
      COND_NO_START:  take = !start;
      COND_MORE_BITS: take = status.more_bits;
      COND_EMPTY:     take = status.empty;
      COND_MATCH:     take = status.match;
      COND_NOT_LAST:  take = !status.last;
      default:        take = 1'b0;
    endcase
    step_next = take ? ctrl.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
    end else begin
      step <= step_next;
    end
  end

  assign busy = (step != S_IDLE);

endmodule

// File: rtl/lphs_datapath.sv
// -----------------------------------------------------------------------------
// lphs_datapath
// Key store, used bits, remainder unit and probe registers of the hash set.
// -----------------------------------------------------------------------------
`include "linear_probe_hash_set_macros.svh"

module lphs_datapath
  import lphs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_word_t           ctrl,
  input  logic                 start,
  input  logic [KEY_WIDTH-1:0] key,
  input  logic                 new_set,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_data,
  output status_t              status,
  output logic                 done,
  output logic                 was_present,
  output logic                 no_room
);

  // The size register cannot reach slots beyond SIZE_MAX, so no storage is kept for them.
  localparam int USED_DEPTH = (TABLE_DEPTH < SIZE_MAX) ? TABLE_DEPTH : SIZE_MAX;
  localparam int PW         = $clog2(USED_DEPTH);
  localparam int BW         = $clog2(KEY_WIDTH);

  logic [CFG_W-1:0]     table_size;
  logic [CFG_W-1:0]     size_eff;
  logic [CFG_W-1:0]     size_reg;
  logic [KEY_WIDTH-1:0] key_reg;
  logic [CFG_W-1:0]     rem;
  logic [CFG_W:0]       trial;
  logic [BW-1:0]        bitcnt;
  logic [PW-1:0]        pos;
  logic [CFG_W-1:0]     pos_inc;
  logic [CFG_W-1:0]     n;
  logic [USED_DEPTH-1:0] used;
  logic [KEY_WIDTH-1:0] mem [USED_DEPTH];
  logic [KEY_WIDTH-1:0] rdata;
  logic                 accept;

  assign accept = (ctrl.op == OP_IDLE) && start;

  always_comb begin
    if (table_size == '0) begin
      size_eff = CFG_W'(1);
    end else if (table_size > CFG_W'(USED_DEPTH)) begin
      size_eff = CFG_W'(USED_DEPTH);
    end else begin
      size_eff = table_size;
    end
  end

  // One restoring step of key modulo size per cycle, most significant key bit first.
  assign trial   = {rem, key_reg[bitcnt]};
  assign pos_inc = CFG_W'(pos) + 1'b1;

  assign status.more_bits = (bitcnt != '0);
  assign status.empty     = !used[pos];
  assign status.match     = (rdata == key_reg);
  assign status.last      = (n == size_reg - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RESET;
    end else if (cfg_we) begin
      table_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (ctrl.op)
        OP_IDLE: begin
          if (accept && new_set) begin
            used <= '0;
          end
        end
        OP_STORE: begin
          used[pos] <= 1'b1;
          done      <= 1'b1;
        end
        OP_HIT, OP_FULL: begin
          done <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_IDLE: begin
        if (accept) begin
          key_reg  <= key;
          size_reg <= size_eff;
          rem      <= '0;
          bitcnt   <= BW'(KEY_WIDTH - 1);
        end
      end
      OP_MOD: begin
        if (trial >= {1'b0, size_reg}) begin
          rem <= CFG_W'(trial - {1'b0, size_reg});
        end else begin
          rem <= trial[CFG_W-1:0];
        end
        bitcnt <= bitcnt - 1'b1;
      end
      OP_SETPOS: begin
        pos <= rem[PW-1:0];
        n   <= '0;
      end
      OP_ADVANCE: begin
        if (pos_inc >= size_reg) begin
          pos <= '0;
        end else begin
          pos <= pos_inc[PW-1:0];
        end
        n <= n + 1'b1;
      end
      OP_STORE: begin
        was_present <= 1'b0;
        no_room     <= 1'b0;
      end
      OP_HIT: begin
        was_present <= 1'b1;
        no_room     <= 1'b0;
      end
      OP_FULL: begin
        was_present <= 1'b0;
        no_room     <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_STORE) begin
      mem[pos] <= key_reg;
    end
    if (ctrl.op == OP_READ) begin
      rdata <= mem[pos];
    end
  end

  `LPHS_ASSERT_NOW(a_result_excl, done, !(was_present && no_room),
    "result reports both present and no room")
  `LPHS_ASSERT_NOW(a_pos_in_range, ctrl.op == OP_READ, CFG_W'(pos) < size_reg,
    "probe position outside the active table")
  `LPHS_ASSERT_NOW(a_rem_in_range, ctrl.op == OP_SETPOS, rem < size_reg,
    "hash remainder not below the table size")
  `LPHS_ASSERT_NEXT(a_store_sets_used, ctrl.op == OP_STORE, done && !was_present && !no_room,
    "store did not report a fresh insertion")

endmodule

// File: rtl/linear_probe_hash_set.sv
// -----------------------------------------------------------------------------
// linear_probe_hash_set
// Open-addressing hash set with linear probing that flags repeated keys.
// -----------------------------------------------------------------------------
// Raise start with key and new_set while busy is low; the item transfers on
// that edge and busy rises on the next cycle. When new_set is high every slot
// is emptied before the key is handled. The key is hashed as key modulo the
// active table size by a restoring remainder step, one key bit per cycle,
// and slots are then probed linearly, wrapping at the active size.
// One result per item appears for exactly one cycle with done high: was_present
// means the key was already stored, no_room means it was absent and the table
// was full; both low means the key has just been stored. The receiver cannot
// stall, so the result transfers on the edge that ends the done cycle.
// After the remainder steps the sequencer sets the probe position, then for
// each probe reads the one key-store port, tests for an empty slot, tests for
// a match and advances; at most as many probes as the active size are made,
// and the item ends with a store, hit or full step that raises done.
// The size register is written through cfg_valid and cfg_ready while idle and
// no item is being offered on start.
// Reset empties the table, sets the size to 11 and returns the sequencer to idle.
// -----------------------------------------------------------------------------
`include "linear_probe_hash_set_macros.svh"

module linear_probe_hash_set
  import lphs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [KEY_WIDTH-1:0] key,
  input  logic                 new_set,
  output logic                 done,
  output logic                 was_present,
  output logic                 no_room,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     cfg_data
);

  ctrl_word_t ctrl;
  status_t    status;

  // A size write never shares an edge with an item transfer.
  assign cfg_ready = !busy && !start;

  lphs_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  lphs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .start       (start),
    .key         (key),
    .new_set     (new_set),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .status      (status),
    .done        (done),
    .was_present (was_present),
    .no_room     (no_room)
  );

  `LPHS_ASSERT_NOW(a_done_when_idle, done, !busy,
    "result presented while the sequencer is still busy")
  `LPHS_ASSERT_NEXT(a_accept_busy, start && !busy, busy,
    "accepted item did not make the block busy")

endmodule
